[design/audio_voice_slot_allocator_assert.svh]
// assertion macros for the voice slot allocator checker
// clocked on clk, disabled while rst is high
`ifndef AUDIO_VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`define AUDIO_VOICE_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define AVSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AVSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/avsa_pkg.sv]
// shared types, constants and helpers of the voice slot allocator
// no dependencies
`default_nettype none

package avsa_pkg;

  localparam int POOL_SLOTS_DEF = 32;
  localparam int GROUP_DEPTH    = 16;
  localparam int GPW            = 4;
  localparam int CW             = 5;
  localparam int LEN_W          = 24;
  localparam int ID_W           = 32;
  localparam int ACT_W          = 6;
  localparam int LIM_W          = 5;
  localparam int CHUNK_W        = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;

  typedef enum logic [2:0] {
    KIND_STARTED   = 3'd0,
    KIND_REFUSED   = 3'd1,
    KIND_STOLEN    = 3'd2,
    KIND_FINISHED  = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MUSIC_LIMIT  = 2'd0,
    REG_EFFECT_LIMIT = 2'd1,
    REG_CHUNK_BYTES  = 2'd2
  } reg_idx_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;
  localparam logic GRP_EFFECT = 1'b0;
  localparam logic GRP_MUSIC  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEAL_ORD,
    ST_STEAL_EMIT,
    ST_ALLOC,
    ST_TICK_NEXT,
    ST_TICK_ORD,
    ST_TICK_EVAL,
    ST_TICK_DONE
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] offset;
    logic [ID_W-1:0]  ident;
  } slot_entry_t;

  function automatic logic [LIM_W-1:0] clamp_limit(input logic [LIM_W-1:0] v);
    logic [LIM_W-1:0] r;
    r = v;
    if (v > LIM_W'(GROUP_DEPTH)) r = LIM_W'(GROUP_DEPTH);
    if (v == '0) r = LIM_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

[design/avsa_ifs.sv]
// request and result channel interfaces of the voice slot allocator
// depends on avsa_pkg
`default_nettype none

interface avsa_in_if
  import avsa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             op;
  logic             voice_group;
  logic [LEN_W-1:0] sound_length;

  modport source(output valid, output op, output voice_group, output sound_length,
                 input ready);
  modport sink(input valid, input op, input voice_group, input sound_length,
               output ready);
endinterface

interface avsa_out_if
  import avsa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [ID_W-1:0]  voice_id;
  logic             group_out;
  logic [ACT_W-1:0] active_voices;
  logic             last;

  modport source(output valid, output kind, output voice_id, output group_out,
                 output active_voices, output last, input ready);
  modport sink(input valid, input kind, input voice_id, input group_out,
               input active_voices, input last, output ready);
endinterface

`default_nettype wire

[design/avsa_slot_mem.sv]
// per-slot length, offset and id store, one write and one registered read port
// depends on avsa_pkg
`default_nettype none

module avsa_slot_mem
  import avsa_pkg::*;
#(
  parameter int SLOTS = POOL_SLOTS_DEF,
  parameter int SW    = $clog2(POOL_SLOTS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [SW-1:0] waddr,
  input  wire slot_entry_t   wdata,
  input  wire logic          re,
  input  wire logic [SW-1:0] raddr,
  output slot_entry_t        rdata
);

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/audio_voice_slot_allocator.sv]
// top level of the voice slot allocator: sequencer, group order queues, outputs
// depends on avsa_pkg, avsa_ifs, avsa_slot_mem
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | op, voice_group, sound_length
//  res     | out | valid / ready | kind, voice_id, group_out, active_voices, last
//  cfg     | in  | cfg_write     | cfg_index, cfg_data
//
// start: check, then alloc, with steal_ord and steal_emit between them when a voice
//   is stolen; the stolen voice and the started or refused voice give one result each
// tick: tick_next, tick_ord and tick_eval per active voice, one tick_next per group end
//   and one tick_done; each voice takes an order queue read and a slot store read
// req is taken only while the sequencer is idle; a full result register holds
//   the sequencer in place until res takes the transfer
// rst is synchronous: busy bits, counts and queue heads clear, the id counter restarts at 1
`default_nettype none

module audio_voice_slot_allocator
  import avsa_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  avsa_in_if.sink                    req,
  avsa_out_if.source                 res,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int OAW = GPW + 1;

  state_t state, state_next;

  // configuration
  logic [LIM_W-1:0]   music_limit, effect_limit;
  logic [CHUNK_W-1:0] chunk_bytes;

  // voice bookkeeping
  logic [POOL_SLOTS-1:0] busy;
  logic [GPW-1:0]        music_head, effect_head;
  logic [CW-1:0]         music_cnt, effect_cnt;
  logic [ID_W-1:0]       next_ident;
  logic [ACT_W-1:0]      active;

  // current item
  logic             grp;
  logic [LEN_W-1:0] len_q;
  logic [CW-1:0]    rd_pos, wr_pos;

  // group order queues, one circular queue per group
  logic [SW-1:0] ord_mem [2*GROUP_DEPTH];
  logic [SW-1:0] order_q;
  logic          ord_re, ord_we;
  logic [OAW-1:0] ord_raddr, ord_waddr;
  logic [SW-1:0] ord_wdata;

  // slot store
  slot_entry_t slot_q, slot_wdata;
  logic        slot_re, slot_we;
  logic [SW-1:0] slot_waddr;

  // result register
  logic             out_valid;
  logic [2:0]       out_kind;
  logic [ID_W-1:0]  out_id;
  logic             out_grp;
  logic [ACT_W-1:0] out_active;
  logic             out_last;
  logic             out_free;

  logic             emit;
  kind_t            e_kind;
  logic [ID_W-1:0]  e_id;
  logic             e_grp;
  logic [ACT_W-1:0] e_active;
  logic             e_last;

  // selected group view
  logic [GPW-1:0]   head_sel;
  logic [CW-1:0]    cnt_sel;
  logic [LIM_W-1:0] lim_sel;
  logic             steal_cond;
  logic             refuse;
  logic             in_take;

  // free slot search
  logic          free_found;
  logic [SW-1:0] free_idx;

  // tick arithmetic
  logic             voice_done;
  logic [LEN_W-1:0] remain, chunk_ext, step;
  logic [ID_W-1:0]  ident_inc;

  assign in_take   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign out_free  = !out_valid || res.ready;

  assign head_sel = grp ? music_head : effect_head;
  assign cnt_sel  = grp ? music_cnt : effect_cnt;
  assign lim_sel  = clamp_limit(grp ? music_limit : effect_limit);
  assign steal_cond = (cnt_sel >= lim_sel) && (cnt_sel != '0);
  assign refuse = !free_found || (cnt_sel >= CW'(GROUP_DEPTH));

  assign voice_done = slot_q.offset >= slot_q.length;
  assign remain     = slot_q.length - slot_q.offset;
  assign chunk_ext  = LEN_W'(chunk_bytes);
  assign step       = (remain < chunk_ext) ? remain : chunk_ext;
  assign ident_inc  = (next_ident + ID_W'(1) == '0) ? ID_W'(1) : next_ident + ID_W'(1);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) state_next = (req.op == OP_TICK) ? ST_TICK_NEXT : ST_CHECK;
      end
      ST_CHECK:      state_next = steal_cond ? ST_STEAL_ORD : ST_ALLOC;
      ST_STEAL_ORD:  state_next = ST_STEAL_EMIT;
      ST_STEAL_EMIT: if (out_free) state_next = ST_ALLOC;
      ST_ALLOC:      if (out_free) state_next = ST_IDLE;
      ST_TICK_NEXT: begin
        if (rd_pos < cnt_sel) state_next = ST_TICK_ORD;
        else if (grp == GRP_EFFECT) state_next = ST_TICK_DONE;
      end
      ST_TICK_ORD:   state_next = ST_TICK_EVAL;
      ST_TICK_EVAL:  if (!voice_done || out_free) state_next = ST_TICK_NEXT;
      ST_TICK_DONE:  if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // memory strobes and result values per state
  always_comb begin
    ord_re     = 1'b0;
    ord_raddr  = {grp, head_sel};
    ord_we     = 1'b0;
    ord_waddr  = {grp, GPW'(head_sel + cnt_sel[GPW-1:0])};
    ord_wdata  = free_idx;
    slot_re    = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = free_idx;
    slot_wdata = '{length: len_q, offset: '0, ident: next_ident};
    emit       = 1'b0;
    e_kind     = KIND_TICK_DONE;
    e_id       = '0;
    e_grp      = 1'b0;
    e_active   = active;
    e_last     = 1'b1;
    unique case (state)
      ST_CHECK: ord_re = 1'b1;
      ST_STEAL_ORD: slot_re = 1'b1;
      ST_STEAL_EMIT: begin
        emit     = out_free;
        e_kind   = KIND_STOLEN;
        e_id     = slot_q.ident;
        e_grp    = grp;
        e_active = active - ACT_W'(1);
        e_last   = 1'b0;
      end
      ST_ALLOC: begin
        emit    = out_free;
        e_grp   = grp;
        if (refuse) begin
          e_kind = KIND_REFUSED;
        end else begin
          e_kind   = KIND_STARTED;
          e_id     = next_ident;
          e_active = active + ACT_W'(1);
          slot_we  = out_free;
          ord_we   = out_free;
        end
      end
      ST_TICK_NEXT: begin
        ord_re    = rd_pos < cnt_sel;
        ord_raddr = {grp, GPW'(head_sel + rd_pos[GPW-1:0])};
      end
      ST_TICK_ORD: slot_re = 1'b1;
      ST_TICK_EVAL: begin
        if (voice_done) begin
          emit     = out_free;
          e_kind   = KIND_FINISHED;
          e_id     = slot_q.ident;
          e_grp    = grp;
          e_active = active - ACT_W'(1);
          e_last   = 1'b0;
        end else begin
          // keep the voice, compact it down to the write position
          slot_we    = 1'b1;
          slot_waddr = order_q;
          slot_wdata = '{length: slot_q.length, offset: slot_q.offset + step,
                         ident: slot_q.ident};
          ord_we     = 1'b1;
          ord_waddr  = {grp, GPW'(head_sel + wr_pos[GPW-1:0])};
          ord_wdata  = order_q;
        end
      end
      ST_TICK_DONE: emit = out_free;
      default: ;
    endcase
  end

  // order queue storage
  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
  end

  always_ff @(posedge clk) begin
    if (ord_re) order_q <= ord_mem[ord_raddr];
  end

  avsa_slot_mem #(
    .SLOTS (POOL_SLOTS),
    .SW    (SW)
  ) u_slot_mem (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (order_q),
    .rdata (slot_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      music_limit  <= LIM_W'(8);
      effect_limit <= LIM_W'(16);
      chunk_bytes  <= CHUNK_W'(10);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MUSIC_LIMIT:  music_limit  <= cfg_data[LIM_W-1:0];
        REG_EFFECT_LIMIT: effect_limit <= cfg_data[LIM_W-1:0];
        REG_CHUNK_BYTES:  chunk_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      busy        <= '0;
      music_head  <= '0;
      effect_head <= '0;
      music_cnt   <= '0;
      effect_cnt  <= '0;
      next_ident  <= ID_W'(1);
      active      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_STEAL_EMIT: begin
          if (out_free) begin
            busy[order_q] <= 1'b0;
            active        <= active - ACT_W'(1);
            if (grp) begin
              music_head <= music_head + GPW'(1);
              music_cnt  <= music_cnt - CW'(1);
            end else begin
              effect_head <= effect_head + GPW'(1);
              effect_cnt  <= effect_cnt - CW'(1);
            end
          end
        end
        ST_ALLOC: begin
          if (out_free && !refuse) begin
            busy[free_idx] <= 1'b1;
            active         <= active + ACT_W'(1);
            next_ident     <= ident_inc;
            if (grp) music_cnt  <= music_cnt + CW'(1);
            else     effect_cnt <= effect_cnt + CW'(1);
          end
        end
        ST_TICK_NEXT: begin
          if (rd_pos >= cnt_sel) begin
            if (grp) music_cnt  <= wr_pos;
            else     effect_cnt <= wr_pos;
          end
        end
        ST_TICK_EVAL: begin
          if (voice_done && out_free) begin
            busy[order_q] <= 1'b0;
            active        <= active - ACT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          grp    <= (req.op == OP_TICK) ? GRP_MUSIC : req.voice_group;
          len_q  <= req.sound_length;
          rd_pos <= '0;
          wr_pos <= '0;
        end
      end
      ST_TICK_NEXT: begin
        // music done, move on to effects
        if (rd_pos >= cnt_sel && grp == GRP_MUSIC) begin
          grp    <= GRP_EFFECT;
          rd_pos <= '0;
          wr_pos <= '0;
        end
      end
      ST_TICK_EVAL: begin
        if (!voice_done) begin
          rd_pos <= rd_pos + CW'(1);
          wr_pos <= wr_pos + CW'(1);
        end else if (out_free) begin
          rd_pos <= rd_pos + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= e_kind;
      out_id     <= e_id;
      out_grp    <= e_grp;
      out_active <= e_active;
      out_last   <= e_last;
    end
  end

  assign res.valid         = out_valid;
  assign res.kind          = out_kind;
  assign res.voice_id      = out_id;
  assign res.group_out     = out_grp;
  assign res.active_voices = out_active;
  assign res.last          = out_last;

endmodule

`default_nettype wire

[design/avsa_checker.sv]
// port-level checks on the result channel of the voice slot allocator
// depends on avsa_pkg and audio_voice_slot_allocator_assert.svh; bound to the top level
`default_nettype none

`include "audio_voice_slot_allocator_assert.svh"

module avsa_port_checker
  import avsa_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [2:0]       kind,
  input wire logic [ID_W-1:0]  voice_id,
  input wire logic             group_out,
  input wire logic [ACT_W-1:0] active_voices,
  input wire logic             last
);

  logic is_tick_done;
  logic tick_done_ok;
  logic is_voice_kind;

  assign is_tick_done  = out_valid && (kind == KIND_TICK_DONE);
  assign tick_done_ok  = last && (voice_id == '0) && !group_out;
  assign is_voice_kind = out_valid &&
                         (kind == KIND_STARTED || kind == KIND_STOLEN ||
                          kind == KIND_FINISHED);

  `AVSA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `AVSA_ASSERT_NOW(a_tick_done, is_tick_done, tick_done_ok, "bad tick done result")
  `AVSA_ASSERT_NOW(a_id_nonzero, is_voice_kind, voice_id != '0, "voice result with zero id")
  `AVSA_ASSERT_NOW(a_active_max, out_valid, active_voices <= ACT_W'(2 * GROUP_DEPTH), "too many")

endmodule

bind audio_voice_slot_allocator avsa_port_checker u_avsa_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .kind          (res.kind),
  .voice_id      (res.voice_id),
  .group_out     (res.group_out),
  .active_voices (res.active_voices),
  .last          (res.last)
);

`default_nettype wire
